### rtl/tafg_pkg.sv
// Package for the turret aim and fire gate: sequencer states, codes,
// CORDIC arctangent table and armor spacing tables.
// No dependencies.
package tafg_pkg;

  localparam int MaxArmorsDef   = 4;
  localparam int CordicStepsDef = 16;

  // Datapath widths of the shared CORDIC unit and multiplier.
  localparam int CordW = 36;
  localparam int ZW    = 34;
  localparam int MulBW = 19;
  localparam int ProdW = CordW + MulBW;
  localparam int DistW = 38;

  localparam logic signed [CordW-1:0] InvGain   = 36'sd652032874;
  localparam logic signed [ZW-1:0]    HalfTurnZ = 34'sd2147483648;
  localparam logic signed [MulBW-1:0] CdegTurn  = 19'sd36000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RINIT,
    S_ROT,
    S_MUL,
    S_VINIT,
    S_VEC,
    S_CONV,
    S_DONE
  } st_e;

  localparam logic OpGimbal = 1'b0;
  localparam logic OpTarget = 1'b1;

  localparam logic [1:0] CfgPitchOfs = 2'd0;
  localparam logic [1:0] CfgYawOfs   = 2'd1;
  localparam logic [1:0] CfgFireTol  = 2'd2;

  // atan(2^-k) as a 32-bit turn angle.
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051D;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2F9;
      5'd15:   v = 32'h0000517C;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A2F;
      5'd19:   v = 32'h00000517;
      5'd20:   v = 32'h0000028B;
      5'd21:   v = 32'h00000145;
      5'd22:   v = 32'h000000A2;
      5'd23:   v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Quotient of one full turn by the armor count.
  function automatic logic [32:0] space_quot(input logic [3:0] n);
    logic [32:0] v;
    case (n)
      4'd1:    v = 33'h100000000;
      4'd2:    v = 33'd2147483648;
      4'd3:    v = 33'd1431655765;
      4'd4:    v = 33'd1073741824;
      4'd5:    v = 33'd858993459;
      4'd6:    v = 33'd715827882;
      4'd7:    v = 33'd613566756;
      4'd8:    v = 33'd536870912;
      default: v = 33'd0;
    endcase
    return v;
  endfunction

  // Remainder of one full turn by the armor count.
  function automatic logic [3:0] space_rem(input logic [3:0] n);
    logic [3:0] v;
    case (n)
      4'd3:    v = 4'd1;
      4'd5:    v = 4'd1;
      4'd6:    v = 4'd4;
      4'd7:    v = 4'd4;
      default: v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/turret_aim_and_fire_gate.sv
// Turret aim and fire gate: armor placement, nearest armor pick, aim angles
// and fire decision on one shared CORDIC unit and one shared multiplier.
// Depends on tafg_pkg.
//
//   channel  direction  handshake                   payload
//   in       sink       in_valid_i / in_stall_o     opcode .. gimbal_yaw
//   out      source     out_valid_o / out_stall_i   aim_pitch .. armor_index
//   cfg      sink       cfg_we_i                    cfg_index_i, cfg_data_i
//
// A gimbal update only stores the gimbal angles and gives no result. A target
// item without a target goes straight to the result, with the stored gimbal
// angles and no fire. A target item runs the single CORDIC unit once per armor
// and twice for the arctangents.
// Reset clears the sequencer, output valid and stored gimbal angles and presets the configuration.
// The input stalls while an item is in work; a finished result waits in the
// output register, and the next item is taken meanwhile.
module turret_aim_and_fire_gate #(
  parameter int MAX_ARMORS   = tafg_pkg::MaxArmorsDef,
  parameter int CORDIC_STEPS = tafg_pkg::CordicStepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic               tracking_i,
  input  logic signed [15:0] center_x_i,
  input  logic signed [15:0] center_y_i,
  input  logic signed [15:0] center_z_i,
  input  logic [15:0]        target_yaw_i,
  input  logic [10:0]        radius_first_i,
  input  logic [10:0]        radius_second_i,
  input  logic signed [10:0] pair_height_offset_i,
  input  logic [2:0]         armor_count_i,
  input  logic signed [15:0] gimbal_pitch_i,
  input  logic signed [15:0] gimbal_yaw_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] aim_pitch_o,
  output logic signed [15:0] aim_yaw_o,
  output logic               fire_o,
  output logic [1:0]         armor_index_o
);
  import tafg_pkg::*;

  localparam int CW = $clog2(MAX_ARMORS + 1);
  localparam int SW = $clog2(CORDIC_STEPS + 1);

  st_e state_q, state_d;

  // Configuration and stored gimbal angles.
  logic signed [9:0]  poff_q, yoff_q;
  logic [14:0]        tol_q;
  logic signed [15:0] cur_pitch_q, cur_yaw_q;

  // Item registers.
  logic signed [15:0] xc_q, yc_q, zc_q;
  logic [31:0]        base_q;
  logic [10:0]        r1_q, r2_q;
  logic signed [10:0] dz_q;
  logic [CW-1:0]      n_q, i_q, best_q;
  logic [32:0]        acc_q;
  logic [3:0]         rem_q;
  logic               notgt_q;

  // Shared CORDIC unit.
  logic signed [CordW-1:0] cx_q, cy_q;
  logic signed [ZW-1:0]    cz_q;
  logic [SW-1:0]           step_q;
  logic                    flip_q;
  logic                    vsel_q, zero_q, cphase_q;
  logic [2:0]              mphase_q;

  // Shared multiplier and distance search.
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [CordW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [17:0]      ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic [DistW-1:0]        dacc_q, best_d_q, dist_sum;
  logic signed [16:0]      cdy_q, cdp_q;

  logic               out_valid_q, fire_q;
  logic signed [15:0] aim_pitch_q, aim_yaw_q;
  logic [1:0]         armor_index_q;

  logic in_take, out_take, out_free;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign out_free   = !out_valid_q || !out_stall_i;

  logic [3:0]    cnt4;
  logic [CW-1:0] n_clamp;
  assign cnt4    = {1'b0, armor_count_i};
  assign n_clamp = (cnt4 > 4'(MAX_ARMORS)) ? CW'(MAX_ARMORS) : CW'(cnt4);

  // Rotation start angle for the current armor.
  logic [31:0]             ang, ang_adj, angz;
  logic                    flip;
  logic                    odd_pair;
  logic [10:0]             r_sel;
  assign ang      = base_q + acc_q[31:0];
  assign ang_adj  = ang + 32'h4000_0000;
  assign flip     = ang_adj[31];
  assign angz     = flip ? (ang - 32'h8000_0000) : ang;
  assign odd_pair = (n_q == CW'(4)) && i_q[0];
  assign r_sel    = odd_pair ? r2_q : r1_q;

  // One CORDIC micro-rotation; the same step serves both modes.
  logic signed [CordW-1:0] sx, sy, nx, ny;
  logic signed [ZW-1:0]    at, nz;
  logic                    dec, step_last;
  assign sx  = cx_q >>> step_q;
  assign sy  = cy_q >>> step_q;
  assign at  = ZW'(atan_turn(5'(step_q)));
  assign dec = (state_q == S_ROT) ? !cz_q[ZW-1] : cy_q[CordW-1];
  assign nx  = dec ? (cx_q - sy) : (cx_q + sy);
  assign ny  = dec ? (cy_q + sx) : (cy_q - sx);
  assign nz  = dec ? (cz_q - at) : (cz_q + at);
  assign step_last = (step_q == SW'(CORDIC_STEPS - 1));

  // Vectoring start values.
  logic signed [17:0]      vnum;
  logic signed [CordW-1:0] vx0, vy0;
  assign vnum = vsel_q ? bz_q : bx_q;
  assign vx0  = CordW'(by_q) <<< 14;
  assign vy0  = CordW'(vnum) <<< 14;

  // Angle in turns, folded into (-half, +half].
  logic signed [32:0] zs;
  assign zs = {cz_q[31] & (|cz_q[30:0]), cz_q[31:0]};

  logic signed [CordW-1:0] cosv, sinv;
  assign cosv = flip_q ? -cx_q : cx_q;
  assign sinv = flip_q ? -cy_q : cy_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == S_CONV) begin
      mul_a = CordW'(zs);
      mul_b = CdegTurn;
    end else begin
      case (mphase_q)
        3'd0: begin
          mul_a = cosv;
          mul_b = MulBW'({1'b0, r_sel});
        end
        3'd1: begin
          mul_a = sinv;
          mul_b = MulBW'({1'b0, r_sel});
        end
        3'd2: begin
          mul_a = CordW'(ax_q);
          mul_b = MulBW'(ax_q);
        end
        3'd3: begin
          mul_a = CordW'(ay_q);
          mul_b = MulBW'(ay_q);
        end
        3'd4: begin
          mul_a = CordW'(az_q);
          mul_b = MulBW'(az_q);
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end
  assign prod_d = ProdW'(mul_a) * ProdW'(mul_b);

  // Armor offset r*cos or r*sin rounded to whole millimetres.
  logic signed [ProdW-1:0] prod_rnd30, prod_rnd32;
  logic signed [17:0]      rnd_mm;
  logic signed [16:0]      cd;
  assign prod_rnd30 = prod_q + (ProdW'(1) <<< 29);
  assign rnd_mm     = prod_rnd30[47:30];
  assign prod_rnd32 = prod_q + (ProdW'(1) <<< 31);
  assign cd         = zero_q ? 17'sd0 : prod_rnd32[48:32];
  assign dist_sum   = dacc_q + DistW'(prod_q);

  logic armor_last, take_best;
  assign armor_last = (i_q + CW'(1) == n_q);
  assign take_best  = (i_q == '0) || (dist_sum < best_d_q);

  logic [3:0] rsum;
  assign rsum = rem_q + space_rem(4'(n_q));

  // Final angles and fire decision.
  function automatic logic signed [16:0] sat180(input logic signed [17:0] v);
    logic signed [16:0] r;
    if (v > 18'sd18000)       r = 17'sd18000;
    else if (v < -18'sd18000) r = -17'sd18000;
    else                      r = 17'(v);
    return r;
  endfunction

  logic signed [16:0] pitch_s, yaw_s;
  logic signed [17:0] dp, dy, adp, ady;
  logic               fire_s;
  assign pitch_s = sat180(18'(cdp_q) + 18'(poff_q));
  assign yaw_s   = sat180(-18'(cdy_q) + 18'(yoff_q));
  assign dp      = 18'(pitch_s) - 18'(cur_pitch_q);
  assign dy      = 18'(yaw_s) - 18'(cur_yaw_q);
  assign adp     = dp[17] ? -dp : dp;
  assign ady     = dy[17] ? -dy : dy;
  assign fire_s  = (adp <= 18'(tol_q)) && (ady <= 18'(tol_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_take && opcode_i == OpTarget) begin
          if (!tracking_i || n_clamp == '0) state_d = S_DONE;
          else                              state_d = S_RINIT;
        end
      end
      S_RINIT: state_d = S_ROT;
      S_ROT: begin
        if (step_last) state_d = S_MUL;
      end
      S_MUL: begin
        if (mphase_q == 3'd5) state_d = armor_last ? S_VINIT : S_RINIT;
      end
      S_VINIT: state_d = S_VEC;
      S_VEC: begin
        if (step_last) state_d = S_CONV;
      end
      S_CONV: begin
        if (cphase_q) state_d = vsel_q ? S_DONE : S_VINIT;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      poff_q      <= 10'sd10;
      yoff_q      <= 10'sd0;
      tol_q       <= 15'd200;
      cur_pitch_q <= '0;
      cur_yaw_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
      else if (out_take)                 out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgPitchOfs: poff_q <= cfg_data_i[9:0];
          CfgYawOfs:   yoff_q <= cfg_data_i[9:0];
          CfgFireTol:  tol_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_take && opcode_i == OpGimbal) begin
        cur_pitch_q <= gimbal_pitch_i;
        cur_yaw_q   <= gimbal_yaw_i;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (state_q)
      S_IDLE: begin
        notgt_q <= !tracking_i || (n_clamp == '0);
        xc_q    <= center_x_i;
        yc_q    <= center_y_i;
        zc_q    <= center_z_i;
        base_q  <= {target_yaw_i, 16'h0000};
        r1_q    <= radius_first_i;
        r2_q    <= radius_second_i;
        dz_q    <= pair_height_offset_i;
        n_q     <= n_clamp;
        i_q     <= '0;
        acc_q   <= '0;
        rem_q   <= '0;
        vsel_q  <= 1'b0;
      end
      S_RINIT: begin
        cx_q     <= InvGain;
        cy_q     <= '0;
        cz_q     <= ZW'($signed(angz));
        flip_q   <= flip;
        step_q   <= '0;
        mphase_q <= 3'd0;
        az_q     <= odd_pair ? (18'(zc_q) + 18'(dz_q)) : 18'(zc_q);
      end
      S_ROT, S_VEC: begin
        cx_q     <= nx;
        cy_q     <= ny;
        cz_q     <= nz;
        step_q   <= step_q + SW'(1);
        cphase_q <= 1'b0;
      end
      S_MUL: begin
        mphase_q <= mphase_q + 3'd1;
        case (mphase_q)
          3'd1: ax_q <= 18'(xc_q) - rnd_mm;
          3'd2: ay_q <= 18'(yc_q) - rnd_mm;
          3'd3: dacc_q <= DistW'(prod_q);
          3'd4: dacc_q <= dist_sum;
          3'd5: begin
            if (take_best) begin
              best_d_q <= dist_sum;
              best_q   <= i_q;
              bx_q     <= ax_q;
              by_q     <= ay_q;
              bz_q     <= az_q;
            end
            i_q <= i_q + CW'(1);
            // Spacing angle floor(i*turn/n) kept as quotient and remainder.
            if (rsum >= 4'(n_q)) begin
              rem_q <= rsum - 4'(n_q);
              acc_q <= acc_q + space_quot(4'(n_q)) + 33'd1;
            end else begin
              rem_q <= rsum;
              acc_q <= acc_q + space_quot(4'(n_q));
            end
          end
          default: ;
        endcase
      end
      S_VINIT: begin
        zero_q <= (vnum == '0) && (by_q == '0);
        step_q <= '0;
        if (by_q[17]) begin
          cx_q <= -vx0;
          cy_q <= -vy0;
          cz_q <= HalfTurnZ;
        end else begin
          cx_q <= vx0;
          cy_q <= vy0;
          cz_q <= '0;
        end
      end
      S_CONV: begin
        cphase_q <= 1'b1;
        if (cphase_q) begin
          if (vsel_q) cdp_q <= cd;
          else        cdy_q <= cd;
          vsel_q <= 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          if (notgt_q) begin
            aim_pitch_q   <= cur_pitch_q;
            aim_yaw_q     <= cur_yaw_q;
            fire_q        <= 1'b0;
            armor_index_q <= 2'd0;
          end else begin
            aim_pitch_q   <= 16'(pitch_s);
            aim_yaw_q     <= 16'(yaw_s);
            fire_q        <= fire_s;
            armor_index_q <= 2'(best_q);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign aim_pitch_o   = aim_pitch_q;
  assign aim_yaw_o     = aim_yaw_q;
  assign fire_o        = fire_q;
  assign armor_index_o = armor_index_q;

endmodule
